@@ design/dprq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dprq_pkg
// Shared constants and controller/datapath interface types for the
// deduplicating pair ring queue.
// ----------------------------------------------------------------------------
package dprq_pkg;

	localparam int unsigned QUEUE_DEPTH = 8;
	localparam int unsigned ID_W        = 8;
	localparam logic [ID_W-1:0] EMPTY_ID = 8'hFF;
	localparam logic [ID_W-1:0] ZERO_ID  = 8'h00;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture the input transaction, clear scan and flags
		logic rd_scan;   // read the slot at the scan index, advance it
		logic pop;       // empty the head slot, advance head
		logic wr_first;  // write the first (or only) id at the tail
		logic wr_second; // write the second id of a pair at the tail
		logic rd_head;   // read the slot at the head index
		logic emit;      // load the output register
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_remove;
		logic has_ids;
		logic is_pair;
		logic head_occ;
		logic dup;
		logic room;
		logic scan_last;
		logic out_free;
	} ctl_sts_t;

endpackage
`default_nettype wire

@@ design/dedup_pair_ring_queue_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_pair_ring_queue_top
// Ring queue of message ids that rejects duplicates and writes pairs
// atomically; one result transaction per command transaction.
// ----------------------------------------------------------------------------
// The block takes one command at a time. A remove, or an add that names no
// id, passes through accept, check, head read and emit before the input is
// ready again. An add that names an id also runs the duplicate check, which
// walks every slot through the single read port of the slot RAM, one slot
// per cycle, and a pair is written through its single write port, first id
// then second id. A rejected add skips the writes. The emit step waits while
// the previous result still waits on m_tready. The input is ready again in
// the cycle after the result is loaded into the output register, so a
// pending result may wait on m_tready while the next command is already
// taken. Slot occupancy lives in flip-flops cleared by reset, so no clearing
// pass is needed; an empty slot reads as 0xFF. Id 0 is never treated as a
// duplicate, and a pair of equal new ids is accepted.
// ----------------------------------------------------------------------------
module dedup_pair_ring_queue_top #(
	parameter int unsigned QUEUE_DEPTH = dprq_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	// command transactions
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,  // [7:0] first_id, [15:8] second_id
	input  wire  [0:0]  s_tuser,  // [0] command (0 add, 1 remove)
	// result transactions
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata   // [0] accepted, [8:1] head_id, [15:9] zero
);

	dprq_pkg::ctl_cmd_t        cmd;
	dprq_pkg::ctl_sts_t        sts;
	logic                      res_accepted;
	logic [dprq_pkg::ID_W-1:0] res_head_id;

	// sequence each transaction
	dprq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold slots, pointers and the result register
	dprq_dp #(
		.DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_command   (s_tuser[0]),
		.in_first_id  (s_tdata[7:0]),
		.in_second_id (s_tdata[15:8]),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_accepted (res_accepted),
		.out_head_id  (res_head_id)
	);

	// pack the result, pad to whole bytes
	assign m_tdata = {7'd0, res_head_id, res_accepted};

endmodule
`default_nettype wire

@@ design/dprq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dprq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dprq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [WIDTH-1:0]         wr_data,
	input  wire                     rd_en,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ design/dprq_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dprq_dp
// Datapath: slot storage, occupancy bits, head/tail pointers, duplicate
// scan compare and the result register.
// ----------------------------------------------------------------------------
module dprq_dp #(
	parameter int unsigned DEPTH = dprq_pkg::QUEUE_DEPTH
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_command,
	input  wire [dprq_pkg::ID_W-1:0]   in_first_id,
	input  wire [dprq_pkg::ID_W-1:0]   in_second_id,
	input  wire dprq_pkg::ctl_cmd_t    cmd,
	output dprq_pkg::ctl_sts_t         sts,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic                       out_accepted,
	output logic [dprq_pkg::ID_W-1:0]  out_head_id
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	logic                      command_q;
	logic [dprq_pkg::ID_W-1:0] a_q;
	logic [dprq_pkg::ID_W-1:0] b_q;
	logic [DEPTH-1:0]          occ_q;
	logic [IDX_W-1:0]          head_q;
	logic [IDX_W-1:0]          tail_q;
	logic [IDX_W-1:0]          scan_idx_q;
	logic [IDX_W-1:0]          scan_idx_s1;
	logic                      scan_vld_s1;
	logic                      dup_q;
	logic                      acc_q;
	logic                      out_vld_q;
	logic                      out_acc_q;
	logic [dprq_pkg::ID_W-1:0] out_id_q;

	logic                      has_a;
	logic                      has_b;
	logic                      wr_en;
	logic [dprq_pkg::ID_W-1:0] wr_data;
	logic                      rd_en;
	logic [IDX_W-1:0]          rd_addr;
	logic [dprq_pkg::ID_W-1:0] rd_data;
	logic                      hit;

	assign has_a = (a_q != dprq_pkg::EMPTY_ID);
	assign has_b = (b_q != dprq_pkg::EMPTY_ID);

	assign wr_en   = cmd.wr_first | cmd.wr_second;
	assign wr_data = (cmd.wr_first && has_a) ? a_q : b_q;
	assign rd_en   = cmd.rd_scan | cmd.rd_head;
	assign rd_addr = cmd.rd_scan ? scan_idx_q : head_q;

	dprq_ram #(
		.WIDTH (dprq_pkg::ID_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// id zero is never a duplicate; empty slots never match
	assign hit = scan_vld_s1 && occ_q[scan_idx_s1] && (rd_data != dprq_pkg::ZERO_ID) &&
		((has_a && (rd_data == a_q)) || (has_b && (rd_data == b_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			scan_vld_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.rd_scan;
			if (cmd.pop) begin
				occ_q[head_q] <= 1'b0;
				head_q        <= inc_wrap(head_q);
			end
			if (wr_en) begin
				occ_q[tail_q] <= 1'b1;
				tail_q        <= inc_wrap(tail_q);
			end
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_idx_q;
		if (cmd.load) begin
			command_q  <= in_command;
			a_q        <= in_first_id;
			b_q        <= in_second_id;
			scan_idx_q <= '0;
			dup_q      <= 1'b0;
			acc_q      <= 1'b0;
		end else begin
			if (cmd.rd_scan) begin
				scan_idx_q <= inc_wrap(scan_idx_q);
			end
			if (hit) begin
				dup_q <= 1'b1;
			end
			if (cmd.pop || cmd.wr_first) begin
				acc_q <= 1'b1;
			end
		end
		if (cmd.emit) begin
			out_acc_q <= acc_q;
			out_id_q  <= occ_q[head_q] ? rd_data : dprq_pkg::EMPTY_ID;
		end
	end

	always_comb begin
		sts.is_remove = (command_q == dprq_pkg::CMD_REMOVE);
		sts.has_ids   = has_a | has_b;
		sts.is_pair   = has_a & has_b;
		sts.head_occ  = occ_q[head_q];
		sts.dup       = dup_q;
		sts.room      = !occ_q[tail_q] && !(has_a && has_b && occ_q[inc_wrap(tail_q)]);
		sts.scan_last = (scan_idx_q == LAST_IDX);
		sts.out_free  = !out_vld_q || out_ready;
	end

	assign out_valid    = out_vld_q;
	assign out_accepted = out_acc_q;
	assign out_head_id  = out_id_q;

	a_wr_empty_slot : assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !occ_q[tail_q])
		else $error("write into an occupied slot");

	a_pop_occupied : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> occ_q[head_q])
		else $error("pop from an empty head slot");

	a_pop_clears : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop && !wr_en |=> !occ_q[$past(head_q)])
		else $error("popped slot still occupied");

	a_emit_free : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_vld_q || out_ready))
		else $error("result register overwritten before taken");

endmodule
`default_nettype wire

@@ design/dprq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dprq_ctrl
// Controller: sequences load, duplicate scan, decide/write, head read and
// result emission for one transaction at a time.
// ----------------------------------------------------------------------------
module dprq_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire dprq_pkg::ctl_sts_t  sts,
	output dprq_pkg::ctl_cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;
	localparam logic [2:0] ST_WRITE2 = 3'd5;
	localparam logic [2:0] ST_HREAD  = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (sts.is_remove) begin
					cmd.pop = sts.head_occ;
					state_d = ST_HREAD;
				end else if (!sts.has_ids) begin
					state_d = ST_HREAD;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!sts.dup && sts.room) begin
					cmd.wr_first = 1'b1;
					state_d      = sts.is_pair ? ST_WRITE2 : ST_HREAD;
				end else begin
					state_d = ST_HREAD;
				end
			end
			ST_WRITE2: begin
				cmd.wr_second = 1'b1;
				state_d       = ST_HREAD;
			end
			ST_HREAD: begin
				cmd.rd_head = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_one_mover : assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.load, cmd.rd_scan, cmd.pop, cmd.wr_first, cmd.wr_second,
			cmd.rd_head, cmd.emit}) <= 1)
		else $error("more than one datapath command in a cycle");

	a_scan_to_drain : assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_scan && sts.scan_last) |=> (state_q == ST_DRAIN))
		else $error("scan did not end in drain");

	a_write_pair : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_second |-> ($past(cmd.wr_first) && $past(sts.is_pair)))
		else $error("second write without a first write of a pair");

endmodule
`default_nettype wire
